@@ hdl/tdr_pkg.sv @@
package tdr_pkg;

  // field and datapath widths
  localparam int DUTY_W = 8;
  localparam int DUR_W  = 26;
  localparam int TIME_W = 32;
  localparam int MAG_W  = 7;
  localparam int PROD_W = MAG_W + DUR_W;
  localparam int DSH_W  = DUR_W + MAG_W - 1;
  localparam int ALU_W  = 34;
  localparam int CNT_W  = 3;

  // saturation limits
  localparam logic signed [DUTY_W-1:0] DUTY_LIMIT   = 8'sd100;
  localparam logic [DUR_W-1:0]         DURATION_MAX = 26'd42949672;

  // top quotient / multiplier bit index
  localparam logic [CNT_W-1:0] TOP_BIT = CNT_W'(MAG_W - 1);

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_PEAK   = 2'd0,
    REG_ACCEL  = 2'd1,
    REG_CRUISE = 2'd2,
    REG_DECEL  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ELAPSED,
    S_ACCEL,
    S_CRUISE,
    S_DECEL,
    S_DECNUM,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  // operation request to the shared adder
  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             carry;
  } alu_rsp_t;

endpackage

@@ hdl/tdr_addsub.sv @@
module tdr_addsub (
  input  tdr_pkg::alu_req_t req,
  output tdr_pkg::alu_rsp_t rsp
);
  import tdr_pkg::*;

  logic [ALU_W:0] sum;

  // a + b, or a - b with carry high when a >= b
  always_comb begin
    sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + (ALU_W+1)'(req.sub);
    rsp.res   = sum[ALU_W-1:0];
    rsp.carry = sum[ALU_W];
  end

endmodule

@@ hdl/trapezoid_duty_ramp_top.sv @@
// start, stop, unused command or update while idle: the sequencer goes straight to S_OUT,
// which registers out_valid once the output is free; update during a ramp: S_ELAPSED,
// the phase tests, then up to 7 multiply + 7 divide steps, then S_OUT; one item in
// flight at a time, and a finished result waits in S_OUT while out_stall holds it; the
// single shared adder steps the phase tests, the shift-add multiply and restoring divide
// reset: rst_n synchronous active low clears config, profile state and out_valid
module trapezoid_duty_ramp_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [tdr_pkg::DUR_W-1:0]             cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_command,
  input  logic [tdr_pkg::TIME_W-1:0]            in_now_time,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tdr_pkg::DUTY_W-1:0]     out_duty_out,
  output logic [1:0]                            out_phase_out,
  output logic                                  out_running_out
);
  import tdr_pkg::*;

  // configuration registers
  logic signed [DUTY_W-1:0] peak_r;
  logic [DUR_W-1:0]         accel_r, cruise_r, decel_r;
  logic signed [DUTY_W-1:0] cfg_duty;
  logic [DUR_W-1:0]         cfg_dur;

  // latched run copies and profile state
  logic signed [DUTY_W-1:0] run_peak_r, run_peak_nxt;
  logic [DUR_W-1:0]         run_accel_r, run_accel_nxt;
  logic [DUR_W-1:0]         run_cruise_r, run_cruise_nxt;
  logic [DUR_W-1:0]         run_decel_r, run_decel_nxt;
  logic [TIME_W-1:0]        start_r, start_nxt;
  logic signed [DUTY_W-1:0] duty_r, duty_nxt;
  phase_t                   phase_r, phase_nxt;
  logic                     running_r, running_nxt;

  // sequencer and datapath
  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] elap_r, elap_nxt;
  logic [DUR_W-1:0]  num_r, num_nxt;
  logic [DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [MAG_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  phase_t            tgt_r, tgt_nxt;
  logic [MAG_W-1:0]  pmag;
  logic signed [DUTY_W-1:0] ramp_duty;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DUTY_W-1:0] out_duty_r, out_duty_nxt;
  phase_t                   out_phase_r, out_phase_nxt;
  logic                     out_running_r, out_running_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  tdr_addsub u_addsub (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // write saturation
  always_comb begin
    cfg_duty = $signed(cfg_wdata[DUTY_W-1:0]);
    if (cfg_duty > DUTY_LIMIT) cfg_duty = DUTY_LIMIT;
    if (cfg_duty < -DUTY_LIMIT) cfg_duty = -DUTY_LIMIT;
    cfg_dur = (cfg_wdata > DURATION_MAX) ? DURATION_MAX : cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r   <= '0;
      accel_r  <= '0;
      cruise_r <= '0;
      decel_r  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PEAK:   peak_r   <= cfg_duty;
        REG_ACCEL:  accel_r  <= cfg_dur;
        REG_CRUISE: cruise_r <= cfg_dur;
        REG_DECEL:  decel_r  <= cfg_dur;
        default: ;
      endcase
    end
  end

  // peak magnitude, at most the duty limit
  always_comb begin
    logic signed [DUTY_W-1:0] neg;
    neg  = -run_peak_r;
    pmag = run_peak_r[DUTY_W-1] ? neg[MAG_W-1:0] : run_peak_r[MAG_W-1:0];
  end

  // final quotient bit folded in, sign of the peak applied
  always_comb begin
    logic [DUTY_W-1:0] mag;
    mag       = {1'b0, q_nxt};
    ramp_duty = run_peak_r[DUTY_W-1] ? -$signed(mag) : $signed(mag);
  end

  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    run_peak_nxt   = run_peak_r;
    run_accel_nxt  = run_accel_r;
    run_cruise_nxt = run_cruise_r;
    run_decel_nxt  = run_decel_r;
    start_nxt      = start_r;
    duty_nxt       = duty_r;
    phase_nxt      = phase_r;
    running_nxt    = running_r;
    now_nxt        = now_r;
    elap_nxt       = elap_r;
    num_nxt        = num_r;
    dsh_nxt        = dsh_r;
    prod_nxt       = prod_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    tgt_nxt        = tgt_r;
    alu_req.sub    = 1'b1;
    alu_req.a      = ALU_W'(elap_r);
    alu_req.b      = '0;

    out_valid_nxt   = out_valid_r && out_stall;
    out_duty_nxt    = out_duty_r;
    out_phase_nxt   = out_phase_r;
    out_running_nxt = out_running_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          now_nxt   = in_now_time;
          state_nxt = S_OUT;
          case (cmd_t'(in_command))
            CMD_START: begin
              run_peak_nxt   = peak_r;
              run_accel_nxt  = accel_r;
              run_cruise_nxt = cruise_r;
              run_decel_nxt  = decel_r;
              start_nxt      = in_now_time;
              duty_nxt       = '0;
              running_nxt    = (peak_r != '0);
              phase_nxt      = (peak_r != '0) ? PH_ACCEL : PH_IDLE;
            end
            CMD_STOP: begin
              duty_nxt    = '0;
              phase_nxt   = PH_IDLE;
              running_nxt = 1'b0;
            end
            CMD_UPDATE: begin
              if (running_r) state_nxt = S_ELAPSED;
            end
            default: ;
          endcase
        end
      end
      // elapsed time modulo the timestamp width
      S_ELAPSED: begin
        alu_req.a = ALU_W'(now_r);
        alu_req.b = ALU_W'(start_r);
        elap_nxt  = alu_rsp.res[TIME_W-1:0];
        state_nxt = S_ACCEL;
      end
      S_ACCEL: begin
        alu_req.b = ALU_W'(run_accel_r);
        if (run_accel_r != '0 && !alu_rsp.carry) begin
          num_nxt   = elap_r[DUR_W-1:0];
          dsh_nxt   = {run_accel_r, (MAG_W-1)'(0)};
          tgt_nxt   = PH_ACCEL;
          prod_nxt  = '0;
          q_nxt     = '0;
          cnt_nxt   = TOP_BIT;
          state_nxt = S_MUL;
        end else begin
          elap_nxt  = alu_rsp.res[TIME_W-1:0];
          state_nxt = S_CRUISE;
        end
      end
      S_CRUISE: begin
        alu_req.b = ALU_W'(run_cruise_r);
        if (!alu_rsp.carry) begin
          duty_nxt  = run_peak_r;
          phase_nxt = PH_CRUISE;
          state_nxt = S_OUT;
        end else begin
          elap_nxt  = alu_rsp.res[TIME_W-1:0];
          state_nxt = S_DECEL;
        end
      end
      S_DECEL: begin
        alu_req.b = ALU_W'(run_decel_r);
        if (run_decel_r != '0 && !alu_rsp.carry) begin
          state_nxt = S_DECNUM;
        end else begin
          // end of the profile
          duty_nxt    = '0;
          phase_nxt   = PH_IDLE;
          running_nxt = 1'b0;
          state_nxt   = S_OUT;
        end
      end
      // time left in the ramp-down
      S_DECNUM: begin
        alu_req.a = ALU_W'(run_decel_r);
        alu_req.b = ALU_W'(elap_r);
        num_nxt   = alu_rsp.res[DUR_W-1:0];
        dsh_nxt   = {run_decel_r, (MAG_W-1)'(0)};
        tgt_nxt   = PH_DECEL;
        prod_nxt  = '0;
        q_nxt     = '0;
        cnt_nxt   = TOP_BIT;
        state_nxt = S_MUL;
      end
      // shift-add multiply, peak magnitude msb first
      S_MUL: begin
        alu_req.sub = 1'b0;
        alu_req.a   = ALU_W'({prod_r, 1'b0});
        alu_req.b   = pmag[cnt_r] ? ALU_W'(num_r) : '0;
        prod_nxt    = alu_rsp.res[PROD_W-1:0];
        if (cnt_r == '0) begin
          cnt_nxt   = TOP_BIT;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      // restoring divide by the phase duration
      S_DIV: begin
        alu_req.a = ALU_W'(prod_r);
        alu_req.b = ALU_W'(dsh_r);
        dsh_nxt   = dsh_r >> 1;
        if (alu_rsp.carry) begin
          prod_nxt     = alu_rsp.res[PROD_W-1:0];
          q_nxt[cnt_r] = 1'b1;
        end
        if (cnt_r == '0) begin
          duty_nxt  = ramp_duty;
          phase_nxt = tgt_r;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_duty_nxt    = duty_r;
          out_phase_nxt   = phase_r;
          out_running_nxt = running_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and profile state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      run_peak_r   <= '0;
      run_accel_r  <= '0;
      run_cruise_r <= '0;
      run_decel_r  <= '0;
      start_r      <= '0;
      duty_r       <= '0;
      phase_r      <= PH_IDLE;
      running_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      run_peak_r   <= run_peak_nxt;
      run_accel_r  <= run_accel_nxt;
      run_cruise_r <= run_cruise_nxt;
      run_decel_r  <= run_decel_nxt;
      start_r      <= start_nxt;
      duty_r       <= duty_nxt;
      phase_r      <= phase_nxt;
      running_r    <= running_nxt;
    end
  end

  // datapath and output payload
  always_ff @(posedge clk) begin
    now_r         <= now_nxt;
    elap_r        <= elap_nxt;
    num_r         <= num_nxt;
    dsh_r         <= dsh_nxt;
    prod_r        <= prod_nxt;
    q_r           <= q_nxt;
    cnt_r         <= cnt_nxt;
    tgt_r         <= tgt_nxt;
    out_duty_r    <= out_duty_nxt;
    out_phase_r   <= out_phase_nxt;
    out_running_r <= out_running_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_duty_out    = out_duty_r;
  assign out_phase_out   = out_phase_r;
  assign out_running_out = out_running_r;

  // checks
  a_run_phase: assert property (@(posedge clk) disable iff (!rst_n)
    running_r == (phase_r != PH_IDLE))
    else $error("running flag and phase disagree");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (duty_r == '0))
    else $error("idle phase with non-zero duty");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_duty_r <= DUTY_LIMIT && out_duty_r >= -DUTY_LIMIT))
    else $error("duty beyond limit");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("transfer accepted without work started");

endmodule

@@ dv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdr_pkg::*;

  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          RANDOM_ITEMS = 1400;
  localparam logic [31:0] T0           = 32'hFFFF_FF00;

  // one result of the duty profile
  typedef struct packed {
    logic signed [DUTY_W-1:0] duty;
    phase_t                   phase;
    logic                     running;
  } ramp_result_t;

  // one line of the directed plan: a register write or a command transfer
  typedef struct {
    bit                 is_cfg;
    reg_idx_t           idx;
    logic [DUR_W-1:0]   wdata;
    cmd_t               cmd;
    logic [TIME_W-1:0]  stamp;
    bit                 typed;
    ramp_result_t       want;
  } stim_row_t;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       cfg_we      = 1'b0;
  logic [1:0]                 cfg_index   = '0;
  logic [DUR_W-1:0]           cfg_wdata   = '0;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_command  = '0;
  logic [TIME_W-1:0]          in_now_time = '0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  logic signed [DUTY_W-1:0]   out_duty_out;
  logic [1:0]                 out_phase_out;
  logic                       out_running_out;

  trapezoid_duty_ramp_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_now_time     (in_now_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_duty_out    (out_duty_out),
    .out_phase_out   (out_phase_out),
    .out_running_out (out_running_out)
  );

  // programmed settings, as seen through the write port
  int          set_peak;
  logic [31:0] set_accel, set_cruise, set_decel;
  // settings latched at the last start
  int          lat_peak;
  logic [31:0] lat_accel, lat_cruise, lat_decel;
  // profile state
  logic [31:0] prof_stamp;
  phase_t      prof_phase;
  logic        prof_running;
  int          prof_duty;

  ramp_result_t duty_expect[$];
  stim_row_t    plan[$];

  int errors      = 0;
  int cycles      = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_writes    = 0;
  int n_directed  = 0;
  int phase_seen[4];
  int burst_left  = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // saturating register write into the predictor's copy of the settings
  function automatic void setting_write(input reg_idx_t idx, input logic [DUR_W-1:0] data);
    int               d;
    logic [DUR_W-1:0] v;
    d = int'($signed(data[DUTY_W-1:0]));
    v = (data > DURATION_MAX) ? DURATION_MAX : data;
    case (idx)
      REG_PEAK: begin
        if (d > int'(DUTY_LIMIT)) d = int'(DUTY_LIMIT);
        if (d < -int'(DUTY_LIMIT)) d = -int'(DUTY_LIMIT);
        set_peak = d;
      end
      REG_ACCEL:  set_accel  = 32'(v);
      REG_CRUISE: set_cruise = 32'(v);
      REG_DECEL:  set_decel  = 32'(v);
      default: ;
    endcase
  endfunction

  // evaluate the trapezoid for one command and advance the profile state
  function automatic ramp_result_t profile_step(input cmd_t cmd, input logic [31:0] stamp);
    logic [31:0]     el;
    int unsigned     pmag;
    longint unsigned mag;
    ramp_result_t    r;
    case (cmd)
      CMD_START: begin
        lat_peak     = set_peak;
        lat_accel    = set_accel;
        lat_cruise   = set_cruise;
        lat_decel    = set_decel;
        prof_stamp   = stamp;
        prof_duty    = 0;
        prof_running = (set_peak != 0);
        prof_phase   = prof_running ? PH_ACCEL : PH_IDLE;
      end
      CMD_STOP: begin
        prof_duty    = 0;
        prof_phase   = PH_IDLE;
        prof_running = 1'b0;
      end
      CMD_UPDATE: begin
        if (prof_running) begin
          el   = stamp - prof_stamp;
          pmag = (lat_peak < 0) ? -lat_peak : lat_peak;
          if (lat_accel != 0 && el < lat_accel) begin
            // rising ramp
            mag        = (64'(pmag) * 64'(el)) / 64'(lat_accel);
            prof_duty  = (lat_peak < 0) ? -int'(mag) : int'(mag);
            prof_phase = PH_ACCEL;
          end else begin
            el = el - lat_accel;
            if (el < lat_cruise) begin
              prof_duty  = lat_peak;
              prof_phase = PH_CRUISE;
            end else begin
              el = el - lat_cruise;
              if (lat_decel != 0 && el < lat_decel) begin
                // falling ramp
                mag        = (64'(pmag) * 64'(lat_decel - el)) / 64'(lat_decel);
                prof_duty  = (lat_peak < 0) ? -int'(mag) : int'(mag);
                prof_phase = PH_DECEL;
              end else begin
                // end of profile
                prof_duty    = 0;
                prof_phase   = PH_IDLE;
                prof_running = 1'b0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.duty    = DUTY_W'(prof_duty);
    r.phase   = prof_phase;
    r.running = prof_running;
    return r;
  endfunction

  function automatic stim_row_t item_row(input cmd_t cmd, input logic [31:0] stamp,
                                         input bit typed, input int duty,
                                         input phase_t ph, input logic run);
    stim_row_t row;
    row.is_cfg       = 1'b0;
    row.idx          = REG_PEAK;
    row.wdata        = '0;
    row.cmd          = cmd;
    row.stamp        = stamp;
    row.typed        = typed;
    row.want.duty    = DUTY_W'(duty);
    row.want.phase   = ph;
    row.want.running = run;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input reg_idx_t idx, input logic [DUR_W-1:0] data);
    stim_row_t row;
    row        = item_row(CMD_NONE, '0, 1'b0, 0, PH_IDLE, 1'b0);
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.wdata  = data;
    return row;
  endfunction

  // one register write, only ever issued while the block is idle
  task automatic write_setting(input reg_idx_t idx, input logic [DUR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    setting_write(idx, data);
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (duty_expect.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // one command transfer, sent in bursts with random gaps
  task automatic send_item(input cmd_t cmd, input logic [31:0] stamp,
                           input bit typed, input ramp_result_t want);
    int           gap;
    ramp_result_t pred;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_now_time <= stamp;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = profile_step(cmd, stamp);
    duty_expect.push_back(typed ? want : pred);
    n_sent++;
    @(negedge clk);
  endtask

  // receiver stalls, switching between patterns
  initial begin
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 80);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    ramp_result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      phase_seen[out_phase_out]++;
      if (duty_expect.size() == 0) begin
        $display("%0t: result with nothing expected: duty %0d phase %0d running %0b",
                 $time, out_duty_out, out_phase_out, out_running_out);
        errors++;
      end else begin
        exp_r = duty_expect.pop_front();
        n_checked++;
        if (out_duty_out !== exp_r.duty) begin
          $display("%0t: duty mismatch, expected %0d, actual %0d",
                   $time, $signed(exp_r.duty), out_duty_out);
          errors++;
        end
        if (out_phase_out !== exp_r.phase) begin
          $display("%0t: phase mismatch, expected %0d, actual %0d",
                   $time, exp_r.phase, out_phase_out);
          errors++;
        end
        if (out_running_out !== exp_r.running) begin
          $display("%0t: running mismatch, expected %0b, actual %0b",
                   $time, exp_r.running, out_running_out);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding",
               $time, duty_expect.size());
      $display("trapezoid_duty_ramp_top test failed");
      $finish;
    end
  end

  initial begin
    logic [31:0]      t_start;
    logic [31:0]      offset;
    logic [31:0]      total;
    logic [31:0]      stride;
    logic [DUR_W-1:0] v;
    int               stop_at;
    int               nupd;
    int               pick;

    set_peak     = 0;
    set_accel    = '0;
    set_cruise   = '0;
    set_decel    = '0;
    lat_peak     = 0;
    lat_accel    = '0;
    lat_cruise   = '0;
    lat_decel    = '0;
    prof_stamp   = '0;
    prof_phase   = PH_IDLE;
    prof_running = 1'b0;
    prof_duty    = 0;

    // idle block: update, start with zero peak, unused command
    plan.push_back(item_row(CMD_UPDATE, 32'd0,   1, 0, PH_IDLE, 1'b0));
    plan.push_back(item_row(CMD_START,  32'd100, 1, 0, PH_IDLE, 1'b0));
    plan.push_back(item_row(CMD_NONE,   32'd5,   1, 0, PH_IDLE, 1'b0));
    // positive peak saturated to the limit, timestamps wrapping through zero
    plan.push_back(cfg_row(REG_PEAK,   26'h000007F));
    plan.push_back(cfg_row(REG_ACCEL,  26'd1000));
    plan.push_back(cfg_row(REG_CRUISE, 26'd500));
    plan.push_back(cfg_row(REG_DECEL,  26'd1000));
    plan.push_back(item_row(CMD_START,  T0,            1, 0,   PH_ACCEL,  1'b1));
    plan.push_back(item_row(CMD_UPDATE, T0,            1, 0,   PH_ACCEL,  1'b1));
    plan.push_back(item_row(CMD_UPDATE, T0 + 32'd500,  1, 50,  PH_ACCEL,  1'b1));
    plan.push_back(item_row(CMD_UPDATE, T0 + 32'd999,  0, 0,   PH_IDLE,   1'b0));
    plan.push_back(item_row(CMD_UPDATE, T0 + 32'd1000, 1, 100, PH_CRUISE, 1'b1));
    plan.push_back(item_row(CMD_UPDATE, T0 + 32'd1499, 0, 0,   PH_IDLE,   1'b0));
    plan.push_back(item_row(CMD_UPDATE, T0 + 32'd1500, 1, 100, PH_DECEL,  1'b1));
    plan.push_back(item_row(CMD_UPDATE, T0 + 32'd2250, 1, 25,  PH_DECEL,  1'b1));
    plan.push_back(item_row(CMD_NONE,   32'h1234_5678, 1, 25,  PH_DECEL,  1'b1));
    plan.push_back(item_row(CMD_UPDATE, T0 + 32'd2500, 1, 0,   PH_IDLE,   1'b0));
    plan.push_back(item_row(CMD_UPDATE, 32'hFFFF_FFFF, 1, 0,   PH_IDLE,   1'b0));
    // negative peak saturated, accel and cruise skipped, longest decel
    plan.push_back(cfg_row(REG_PEAK,   26'h0000080));
    plan.push_back(cfg_row(REG_ACCEL,  26'd0));
    plan.push_back(cfg_row(REG_CRUISE, 26'd0));
    plan.push_back(cfg_row(REG_DECEL,  26'h3FFFFFF));
    plan.push_back(item_row(CMD_START,  32'd0,        1, 0,    PH_ACCEL, 1'b1));
    plan.push_back(item_row(CMD_UPDATE, 32'd0,        1, -100, PH_DECEL, 1'b1));
    plan.push_back(item_row(CMD_UPDATE, 32'd21474836, 1, -50,  PH_DECEL, 1'b1));
    plan.push_back(item_row(CMD_START,  32'd1000,     1, 0,    PH_ACCEL, 1'b1));
    plan.push_back(item_row(CMD_STOP,   32'd0,        1, 0,    PH_IDLE,  1'b0));
    // upper bits ignored on peak, longest accel, three-unit cruise and one-unit decel edges
    plan.push_back(cfg_row(REG_PEAK,   26'h2AAAA05));
    plan.push_back(cfg_row(REG_ACCEL,  26'h28F5C29));
    plan.push_back(cfg_row(REG_CRUISE, 26'd3));
    plan.push_back(cfg_row(REG_DECEL,  26'd1));
    plan.push_back(item_row(CMD_START,  32'd7,        1, 0, PH_ACCEL,  1'b1));
    plan.push_back(item_row(CMD_UPDATE, 32'd42949678, 0, 0, PH_IDLE,   1'b0));
    plan.push_back(item_row(CMD_UPDATE, 32'd42949679, 1, 5, PH_CRUISE, 1'b1));
    plan.push_back(item_row(CMD_UPDATE, 32'd42949682, 1, 5, PH_DECEL,  1'b1));
    plan.push_back(item_row(CMD_UPDATE, 32'd42949683, 1, 0, PH_IDLE,   1'b0));

    // reset
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_setting(plan[i].idx, plan[i].wdata);
      end else begin
        send_item(plan[i].cmd, plan[i].stamp, plan[i].typed, plan[i].want);
      end
    end
    n_directed = n_sent;

    // random phases, each under fresh settings
    while (n_sent < n_directed + RANDOM_ITEMS) begin
      drain_results();
      pick = $urandom_range(0, 9);
      case (pick)
        0:       v = '0;
        1:       v = DUR_W'(DUTY_LIMIT);
        2:       v = DUR_W'(-int'(DUTY_LIMIT));
        3:       v = DUR_W'($urandom());
        default: v = DUR_W'($urandom_range(1, 200) - 100);
      endcase
      write_setting(REG_PEAK, v);
      for (int k = 1; k < 4; k++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       v = '0;
          1:       v = DUR_W'($urandom_range(1, 8));
          2:       v = DURATION_MAX;
          3:       v = DUR_W'($urandom());
          default: v = DUR_W'($urandom_range(1, 2000));
        endcase
        write_setting(reg_idx_t'(k), v);
      end

      stop_at = n_sent + $urandom_range(60, 140);
      while (n_sent < stop_at) begin
        if ($urandom_range(0, 19) == 0) drain_results();
        if ($urandom_range(0, 4) != 0) begin
          // well-formed ramp: start, then updates marching through the profile
          t_start = $urandom();
          send_item(CMD_START, t_start, 1'b0, '0);
          total  = lat_accel + lat_cruise + lat_decel;
          nupd   = $urandom_range(3, 12);
          stride = total / nupd + 1;
          offset = '0;
          repeat (nupd) begin
            offset = offset + $urandom_range(0, 2 * stride);
            pick   = $urandom_range(0, 15);
            if (pick == 0) send_item(CMD_NONE, $urandom(), 1'b0, '0);
            else if (pick == 1) send_item(CMD_UPDATE, $urandom(), 1'b0, '0);
            else send_item(CMD_UPDATE, t_start + offset, 1'b0, '0);
          end
          if ($urandom_range(0, 2) == 0) send_item(CMD_STOP, $urandom(), 1'b0, '0);
        end else begin
          // noise
          repeat ($urandom_range(1, 6))
            send_item(cmd_t'($urandom_range(0, 3)), $urandom(), 1'b0, '0);
        end
      end
    end

    // wind down
    drain_results();
    repeat (40) @(posedge clk);
    if (duty_expect.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, duty_expect.size());
      errors++;
    end
    $display("%0d command transfers (%0d directed), %0d results checked, %0d register writes",
             n_sent, n_directed, n_checked, n_writes);
    $display("results by phase: idle %0d, accel %0d, cruise %0d, decel %0d",
             phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3]);
    if (errors == 0) begin
      $display("trapezoid_duty_ramp_top test passed");
    end else begin
      $display("trapezoid_duty_ramp_top test failed");
    end
    $finish;
  end

endmodule
